// ----- src/hwc_pkg.sv -----
package hwc_pkg;

    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 24;

    localparam int CFG_BITS     = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int PHASE_BITS   = 32;
    localparam int OFF_BITS     = 30;
    localparam int SEED_FRAC    = 16;
    localparam int SINE_BITS    = 25;
    localparam int WEIGHT_BITS  = 26;
    localparam int FRAC_BITS    = 23;
    localparam int ACC_BITS     = 48;
    localparam int MAG_HALF     = ACC_BITS / 2;
    localparam int GAIN_HALF    = CFG_BITS / 2;
    localparam int GAIN_FRAC    = 24;
    localparam int PROD_BITS    = ACC_BITS + CFG_BITS;
    localparam int OUT_BITS     = 32;
    localparam int PART_BITS    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CARRIER_STEP = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_STEP  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_NORM    = 2'd2;

    localparam logic [PART_BITS-1:0] PART_LAST = 2'd3;

    localparam longint unsigned Q_ONE30    = 64'd1073741824;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned UNIT_Q23   = 64'd8388608;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SEED_C,
        OP_SEED_W,
        OP_TAB,
        OP_MUL_W,
        OP_MUL_C,
        OP_MUL_S,
        OP_MAG,
        OP_PART,
        OP_FIN_RE
    } t_dp_op;

    typedef struct packed {
        logic                 load;
        t_dp_op               op;
        logic [PART_BITS-1:0] part;
        logic                 emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_status;

    // sin(2*pi*r/N) in Q1.23 for r in [0, N/4], quarter-wave polynomial
    function automatic logic signed [SINE_BITS-1:0] quarter_sine(input int unsigned r,
                                                                 input int addr_bits);
        longint unsigned rr;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        rr = 64'(r);
        x  = (rr * TWO_PI_Q30) >> addr_bits;
        x2 = (x * x) >> 30;
        t  = Q_ONE30;
        t  = Q_ONE30 - ((x2 * t) >> 30) / 64'd110;
        t  = Q_ONE30 - ((x2 * t) >> 30) / 64'd72;
        t  = Q_ONE30 - ((x2 * t) >> 30) / 64'd42;
        t  = Q_ONE30 - ((x2 * t) >> 30) / 64'd20;
        t  = Q_ONE30 - ((x2 * t) >> 30) / 64'd6;
        s  = (((x * t) >> 30) + 64'd64) >> 7;
        if (s > UNIT_Q23) begin
            s = UNIT_Q23;
        end
        return SINE_BITS'(s);
    endfunction

endpackage

// ----- src/hann_wavelet_correlator.sv -----
// Channel    Direction  Handshake                    Payload
// input      in         i_in_valid / o_in_ready      i_sample, i_first, i_last, i_start_offset
// output     out        o_out_valid / i_out_ready    o_corr_real, o_corr_imag
// config     in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// A sample runs through a table read, then three passes through the one shared
// multiplier (window weight, real product, imaginary product). A first item is
// seeded first, the two phases one after the other on the same multiplier. A
// last item adds the output scale and load, the 48x32 scale running as four
// 24x16 partial products per part; only then is the next item taken.
// Reset (synchronous, active low) clears config, phases and accumulators; no
// item is taken in the cycle after reset. A stalled output blocks only the next
// result; further items are taken until a last item must wait for the register.
module hann_wavelet_correlator #(
    parameter int TABLE_ADDR_BITS = hwc_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = hwc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [hwc_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [hwc_pkg::CFG_BITS-1:0]          i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic                                  i_first,
    input  logic                                  i_last,
    input  logic signed [hwc_pkg::OFF_BITS-1:0]   i_start_offset,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [hwc_pkg::OUT_BITS-1:0]   o_corr_real,
    output logic signed [hwc_pkg::OUT_BITS-1:0]   o_corr_imag
);

    hwc_pkg::t_dp_cmd    w_cmd;
    hwc_pkg::t_dp_status w_status;

    hwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_first    (i_first),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    hwc_datapath #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .i_start_offset (i_start_offset),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_corr_real    (o_corr_real),
        .o_corr_imag    (o_corr_imag)
    );

endmodule

// ----- src/hwc_sine_rom.sv -----
module hwc_sine_rom #(
    parameter int TABLE_ADDR_BITS = hwc_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic [TABLE_ADDR_BITS-1:0]             i_index,
    output logic signed [hwc_pkg::SINE_BITS-1:0]   o_value
);

    localparam int QN = 1 << (TABLE_ADDR_BITS - 2);
    localparam logic [TABLE_ADDR_BITS-2:0] QN_IDX = (TABLE_ADDR_BITS - 1)'(QN);

    logic signed [hwc_pkg::SINE_BITS-1:0] w_quarter [QN+1];
    logic [1:0]                           w_quad;
    logic [TABLE_ADDR_BITS-2:0]           w_rem;
    logic [TABLE_ADDR_BITS-2:0]           w_fold;
    logic signed [hwc_pkg::SINE_BITS-1:0] w_mag;

    for (genvar gi = 0; gi <= QN; gi++) begin : g_quarter
        localparam logic signed [hwc_pkg::SINE_BITS-1:0] ENTRY =
            hwc_pkg::quarter_sine(gi, TABLE_ADDR_BITS);
        assign w_quarter[gi] = ENTRY;
    end

    assign w_quad = i_index[TABLE_ADDR_BITS-1 -: 2];
    assign w_rem  = {1'b0, i_index[TABLE_ADDR_BITS-3:0]};
    // second and fourth quadrants run the quarter wave backwards
    assign w_fold = w_quad[0] ? (QN_IDX - w_rem) : w_rem;
    assign w_mag  = w_quarter[w_fold];
    assign o_value = w_quad[1] ? -w_mag : w_mag;

endmodule

// ----- src/hwc_datapath.sv -----
module hwc_datapath #(
    parameter int TABLE_ADDR_BITS = hwc_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = hwc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [hwc_pkg::CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [hwc_pkg::CFG_BITS-1:0]             i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]            i_sample,
    input  logic                                     i_last,
    input  logic signed [hwc_pkg::OFF_BITS-1:0]      i_start_offset,
    input  hwc_pkg::t_dp_cmd                         i_cmd,
    output hwc_pkg::t_dp_status                      o_status,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [hwc_pkg::OUT_BITS-1:0]      o_corr_real,
    output logic signed [hwc_pkg::OUT_BITS-1:0]      o_corr_imag
);

    localparam int PB  = hwc_pkg::PHASE_BITS;
    localparam int AB  = hwc_pkg::ACC_BITS;
    localparam int WX  = SAMPLE_BITS + 2;
    localparam int MA  = (WX > hwc_pkg::CFG_BITS + 1) ? WX : hwc_pkg::CFG_BITS + 1;
    localparam int MB  = hwc_pkg::OFF_BITS;
    localparam int PW  = MA + MB;
    localparam int RW  = (PW + 1 > AB + hwc_pkg::FRAC_BITS) ? PW + 1 : AB + hwc_pkg::FRAC_BITS;
    localparam int PRB = hwc_pkg::PROD_BITS;
    localparam int QB  = PRB - hwc_pkg::GAIN_FRAC;
    localparam int PTB = hwc_pkg::MAG_HALF + hwc_pkg::GAIN_HALF;
    localparam logic [TABLE_ADDR_BITS-1:0] QUARTER = TABLE_ADDR_BITS'(1) << (TABLE_ADDR_BITS - 2);
    localparam logic [RW-1:0]  HALF_LSB = RW'(1) << (hwc_pkg::FRAC_BITS - 1);
    localparam logic [PRB-1:0] HALF_OUT = PRB'(1) << (hwc_pkg::GAIN_FRAC - 1);
    localparam logic signed [hwc_pkg::WEIGHT_BITS-1:0] UNIT =
        hwc_pkg::WEIGHT_BITS'(1) << hwc_pkg::FRAC_BITS;

    logic [hwc_pkg::CFG_BITS-1:0] r_carrier_step;
    logic [hwc_pkg::CFG_BITS-1:0] r_window_step;
    logic [hwc_pkg::CFG_BITS-1:0] r_gain_norm;

    logic signed [SAMPLE_BITS-1:0]            r_sample;
    logic                                     r_last;
    logic signed [hwc_pkg::OFF_BITS-1:0]      r_off;

    logic [PB-1:0]                            r_cphase;
    logic [PB-1:0]                            r_wphase;
    logic signed [AB-1:0]                     r_acc_re;
    logic signed [AB-1:0]                     r_acc_im;

    logic signed [hwc_pkg::WEIGHT_BITS-1:0]   r_weight;
    logic signed [hwc_pkg::SINE_BITS-1:0]     r_cos;
    logic signed [hwc_pkg::SINE_BITS-1:0]     r_sin;
    logic signed [WX-1:0]                     r_wx;

    logic                                     r_neg;
    logic [AB-1:0]                            r_mag;
    logic [PRB-1:0]                           r_prod;
    logic signed [hwc_pkg::OUT_BITS-1:0]      r_re_hold;

    logic                                     r_out_valid;
    logic signed [hwc_pkg::OUT_BITS-1:0]      r_corr_re;
    logic signed [hwc_pkg::OUT_BITS-1:0]      r_corr_im;

    logic [TABLE_ADDR_BITS-1:0]               w_cidx;
    logic [TABLE_ADDR_BITS-1:0]               w_widx;
    logic [TABLE_ADDR_BITS-1:0]               w_cidx_cos;
    logic [TABLE_ADDR_BITS-1:0]               w_widx_cos;
    logic signed [hwc_pkg::SINE_BITS-1:0]     w_wcos;
    logic signed [hwc_pkg::SINE_BITS-1:0]     w_ccos;
    logic signed [hwc_pkg::SINE_BITS-1:0]     w_csin;

    logic signed [MA-1:0]                     w_mul_a;
    logic signed [MB-1:0]                     w_mul_b;
    logic signed [PW-1:0]                     w_prod;
    logic [RW-1:0]                            w_rnd;
    logic [AB-1:0]                            w_term;
    logic [PRB-1:0]                           w_part;
    logic [PRB-1:0]                           w_part_sh;
    logic                                     w_out_free;

    function automatic logic [AB-1:0] abs_acc(input logic signed [AB-1:0] acc);
        return acc[AB-1] ? (AB'(0) - acc) : acc;
    endfunction

    // round half away from zero on the magnitude, then saturate
    function automatic logic signed [hwc_pkg::OUT_BITS-1:0] scale_sat(input logic [PRB-1:0] p,
                                                                      input logic neg);
        logic [PRB-1:0] sum;
        logic [QB-1:0]  q;
        logic           ovf;
        logic signed [hwc_pkg::OUT_BITS-1:0] res;
        sum = p + HALF_OUT;
        q   = sum[PRB-1:hwc_pkg::GAIN_FRAC];
        ovf = |q[QB-1:hwc_pkg::OUT_BITS-1];
        if (neg) begin
            res = ovf ? {1'b1, {(hwc_pkg::OUT_BITS-1){1'b0}}}
                      : (hwc_pkg::OUT_BITS'(0) - q[hwc_pkg::OUT_BITS-1:0]);
        end else begin
            res = ovf ? {1'b0, {(hwc_pkg::OUT_BITS-1){1'b1}}} : q[hwc_pkg::OUT_BITS-1:0];
        end
        return res;
    endfunction

    assign w_cidx     = r_cphase[PB-1 -: TABLE_ADDR_BITS];
    assign w_widx     = r_wphase[PB-1 -: TABLE_ADDR_BITS];
    assign w_cidx_cos = w_cidx + QUARTER;
    assign w_widx_cos = w_widx + QUARTER;

    hwc_sine_rom #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_rom_wcos (
        .i_index (w_widx_cos),
        .o_value (w_wcos)
    );

    hwc_sine_rom #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_rom_ccos (
        .i_index (w_cidx_cos),
        .o_value (w_ccos)
    );

    hwc_sine_rom #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_rom_csin (
        .i_index (w_cidx),
        .o_value (w_csin)
    );

    // shared multiplier operand selection
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            hwc_pkg::OP_SEED_C: begin
                w_mul_a = MA'(r_carrier_step);
                w_mul_b = r_off;
            end
            hwc_pkg::OP_SEED_W: begin
                w_mul_a = MA'(r_window_step);
                w_mul_b = r_off;
            end
            hwc_pkg::OP_MUL_W: begin
                w_mul_a = MA'(r_sample);
                w_mul_b = MB'(r_weight);
            end
            hwc_pkg::OP_MUL_C: begin
                w_mul_a = MA'(r_wx);
                w_mul_b = MB'(r_cos);
            end
            hwc_pkg::OP_MUL_S: begin
                w_mul_a = MA'(r_wx);
                w_mul_b = MB'(r_sin);
            end
            hwc_pkg::OP_PART: begin
                w_mul_a = i_cmd.part[1] ? MA'(r_mag[AB-1 -: hwc_pkg::MAG_HALF])
                                        : MA'(r_mag[hwc_pkg::MAG_HALF-1:0]);
                w_mul_b = i_cmd.part[0] ? MB'(r_gain_norm[hwc_pkg::CFG_BITS-1 -: hwc_pkg::GAIN_HALF])
                                        : MB'(r_gain_norm[hwc_pkg::GAIN_HALF-1:0]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_rnd  = RW'(w_prod) + HALF_LSB;
    assign w_term = w_rnd[hwc_pkg::FRAC_BITS +: AB];
    assign w_part = PRB'(w_prod[PTB-1:0]);

    always_comb begin
        w_part_sh = w_part;
        unique case (i_cmd.part)
            2'd0:    w_part_sh = w_part;
            2'd1:    w_part_sh = w_part << hwc_pkg::GAIN_HALF;
            2'd2:    w_part_sh = w_part << hwc_pkg::MAG_HALF;
            default: w_part_sh = w_part << (hwc_pkg::MAG_HALF + hwc_pkg::GAIN_HALF);
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_step <= '0;
            r_window_step  <= '0;
            r_gain_norm    <= '0;
            r_cphase       <= '0;
            r_wphase       <= '0;
            r_acc_re       <= '0;
            r_acc_im       <= '0;
            r_last         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hwc_pkg::CFG_CARRIER_STEP: r_carrier_step <= i_cfg_data;
                    hwc_pkg::CFG_WINDOW_STEP:  r_window_step  <= i_cfg_data;
                    hwc_pkg::CFG_GAIN_NORM:    r_gain_norm    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_last  <= i_last;
            end

            unique case (i_cmd.op)
                hwc_pkg::OP_SEED_C: begin
                    r_cphase <= w_prod[hwc_pkg::SEED_FRAC +: PB];
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end
                hwc_pkg::OP_SEED_W: r_wphase <= w_prod[hwc_pkg::SEED_FRAC +: PB];
                hwc_pkg::OP_MUL_C:  r_acc_re <= r_acc_re + w_term;
                hwc_pkg::OP_MUL_S: begin
                    r_acc_im <= r_acc_im - w_term;
                    r_cphase <= r_cphase + r_carrier_step;
                    r_wphase <= r_wphase + r_window_step;
                end
                default: ;
            endcase

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_off    <= i_start_offset;
        end

        unique case (i_cmd.op)
            hwc_pkg::OP_TAB: begin
                r_weight <= UNIT + hwc_pkg::WEIGHT_BITS'(w_wcos);
                r_cos    <= w_ccos;
                r_sin    <= w_csin;
            end
            hwc_pkg::OP_MUL_W: r_wx <= w_rnd[hwc_pkg::FRAC_BITS +: WX];
            hwc_pkg::OP_MAG: begin
                r_neg  <= r_acc_re[AB-1];
                r_mag  <= abs_acc(r_acc_re);
                r_prod <= '0;
            end
            hwc_pkg::OP_PART: r_prod <= r_prod + w_part_sh;
            hwc_pkg::OP_FIN_RE: begin
                r_re_hold <= scale_sat(r_prod, r_neg);
                r_neg     <= r_acc_im[AB-1];
                r_mag     <= abs_acc(r_acc_im);
                r_prod    <= '0;
            end
            default: ;
        endcase

        if (i_cmd.emit) begin
            r_corr_re <= r_re_hold;
            r_corr_im <= scale_sat(r_prod, r_neg);
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_corr_real       = r_corr_re;
    assign o_corr_imag       = r_corr_im;

endmodule

// ----- src/hwc_ctrl.sv -----
module hwc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_first,
    output logic                 o_in_ready,
    input  hwc_pkg::t_dp_status  i_status,
    output hwc_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED_C,
        S_SEED_W,
        S_TAB,
        S_MUL_W,
        S_MUL_C,
        S_MUL_S,
        S_MAG,
        S_SC_RE,
        S_FIN_RE,
        S_SC_IM,
        S_EMIT
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [hwc_pkg::PART_BITS-1:0] r_part;
    logic [hwc_pkg::PART_BITS-1:0] n_part;
    logic                          r_ready;
    logic                          n_ready;
    logic                          w_accept;

    assign w_accept = i_in_valid && r_ready;

    always_comb begin
        n_state     = r_state;
        n_part      = r_part;
        o_cmd.load  = w_accept;
        o_cmd.op    = hwc_pkg::OP_NONE;
        o_cmd.part  = r_part;
        o_cmd.emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_first ? S_SEED_C : S_TAB;
                end
            end
            S_SEED_C: begin
                o_cmd.op = hwc_pkg::OP_SEED_C;
                n_state  = S_SEED_W;
            end
            S_SEED_W: begin
                o_cmd.op = hwc_pkg::OP_SEED_W;
                n_state  = S_TAB;
            end
            S_TAB: begin
                o_cmd.op = hwc_pkg::OP_TAB;
                n_state  = S_MUL_W;
            end
            S_MUL_W: begin
                o_cmd.op = hwc_pkg::OP_MUL_W;
                n_state  = S_MUL_C;
            end
            S_MUL_C: begin
                o_cmd.op = hwc_pkg::OP_MUL_C;
                n_state  = S_MUL_S;
            end
            S_MUL_S: begin
                // the next item may be taken here unless this one closes a window
                o_cmd.op = hwc_pkg::OP_MUL_S;
                priority if (i_status.last) begin
                    n_state = S_MAG;
                end else if (w_accept) begin
                    n_state = i_first ? S_SEED_C : S_TAB;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MAG: begin
                o_cmd.op = hwc_pkg::OP_MAG;
                n_part   = '0;
                n_state  = S_SC_RE;
            end
            S_SC_RE: begin
                o_cmd.op = hwc_pkg::OP_PART;
                n_part   = r_part + 1'b1;
                if (r_part == hwc_pkg::PART_LAST) begin
                    n_state = S_FIN_RE;
                end
            end
            S_FIN_RE: begin
                o_cmd.op = hwc_pkg::OP_FIN_RE;
                n_part   = '0;
                n_state  = S_SC_IM;
            end
            S_SC_IM: begin
                o_cmd.op = hwc_pkg::OP_PART;
                n_part   = r_part + 1'b1;
                if (r_part == hwc_pkg::PART_LAST) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ready = (n_state == S_IDLE) || ((n_state == S_MUL_S) && !i_status.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_part  <= '0;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

endmodule
